[design/bnps_pkg.sv]
package bnps_pkg;
  localparam int CW = 32;
  localparam int TF = 16;
  localparam int TW = TF + 1;
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_CONTROL_X = 3'd2;
  localparam logic [2:0] REG_CONTROL_Y = 3'd3;
  localparam logic [2:0] REG_END_X = 3'd4;
  localparam logic [2:0] REG_END_Y = 3'd5;
  localparam logic [2:0] REG_NSAMP = 3'd6;
endpackage

[design/bnps_divider.sv]
module bnps_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [26:0] dividend,
  input  logic [9:0]  divisor,
  output logic [16:0] quotient,
  output logic        done
);
  logic [26:0] q;
  logic [9:0]  r;
  logic [4:0]  cnt;
  logic        busy;
  logic [10:0] rs;

  assign rs = {r, q[26]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        r    <= '0;
        cnt  <= 5'd27;
      end else if (busy) begin
        if (rs >= {1'b0, divisor}) begin
          r <= 10'(rs - {1'b0, divisor});
          q <= {q[25:0], 1'b1};
        end else begin
          r <= rs[9:0];
          q <= {q[25:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q[16:0];
endmodule

[design/bezier_nearest_point_search.sv]
// Finds which of the configured number of evenly spaced samples (register 6, values below 2
// act as 2, values above MAX_SAMPLES act as MAX_SAMPLES) on a quadratic Bezier curve lies
// nearest to a query point. Each sample starts a 27-step serial divide for its parameter,
// waits for the quotient, and runs 12 sequencer steps that pass three weights, six
// weight-coordinate products and two squares through one shared 33x33 multiplier and then
// compare the distance. The result is then loaded into the output register once it is
// free, and the next request is taken after that, even while the result still waits.
module bezier_nearest_point_search #(
  parameter int MAX_SAMPLES = 1023
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // query_x, query_y, t_low, t_high, zero fill
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // best_t, best_x, best_y, best_dist_sq, zero fill
  output logic [151:0] m_tdata
);
  localparam int CW = bnps_pkg::CW;
  localparam int TW = bnps_pkg::TW;
  localparam logic [TW-1:0] T_ONE = TW'(1 << bnps_pkg::TF);
  localparam logic [63:0] HALF = 64'd1 << (2 * bnps_pkg::TF - 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2, S_CALC = 3'd3,
    S_OUT = 3'd4;
  localparam logic [3:0] ST_UU = 4'd0, ST_UT = 4'd1, ST_TT = 4'd2, ST_X0 = 4'd3,
    ST_X1 = 4'd4, ST_X2 = 4'd5, ST_Y0 = 4'd6, ST_Y1 = 4'd7, ST_Y2 = 4'd8, ST_DX = 4'd9,
    ST_DY = 4'd10, ST_CMP = 4'd11;

  logic [CW-1:0] cr [6];
  logic [9:0] scount;
  logic [2:0] state;
  logic [3:0] step;
  logic [CW-1:0] qx, qy;
  logic [TW-1:0] tlo, span, t, u;
  logic [9:0] n, idx, n_in;
  logic [32:0] w [3];
  logic [63:0] acc;
  logic [CW-1:0] px;
  logic [63:0] dx2;
  logic [TW-1:0] bt;
  logic [CW-1:0] bx, by;
  logic [63:0] bd;
  logic first;
  logic [144:0] res;
  logic dstart, ddone;
  logic [TW-1:0] dq;
  logic [26:0] dividend;
  logic [9:0] divisor;
  logic [32:0] ma, mb;
  logic [63:0] prod;
  logic [CW-1:0] da, db, mag;
  logic [64:0] dsum;
  logic [63:0] dsat;
  logic [TW-1:0] ain, bin, a_lo, a_hi;

  function automatic logic [CW-1:0] ofs(input logic [CW-1:0] v);
    return {~v[CW-1], v[CW-2:0]};
  endfunction

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[4:2] < bnps_pkg::REG_NSAMP) prdata = cr[paddr[4:2]];
    else if (paddr[4:2] == bnps_pkg::REG_NSAMP) prdata = {22'd0, scount};
  end

  always_comb begin
    ain = s_tdata[80:64] > T_ONE ? T_ONE : s_tdata[80:64];
    bin = s_tdata[97:81] > T_ONE ? T_ONE : s_tdata[97:81];
    a_lo = ain < bin ? ain : bin;
    a_hi = ain < bin ? bin : ain;
    n_in = scount < 10'd2 ? 10'd2 :
           (32'(scount) > MAX_SAMPLES ? 10'(MAX_SAMPLES) : scount);
  end

  assign u = T_ONE - t;
  assign dstart = (state == S_DIV);
  assign dividend = {17'd0, idx} * {10'd0, span};
  assign divisor = n - 10'd1;

  bnps_divider u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .dividend(dividend), .divisor(divisor),
    .quotient(dq), .done(ddone)
  );

  always_comb begin
    da = px;
    db = qx;
    if (step == ST_DY) begin
      da = acc[63:32];
      db = qy;
    end
    mag = (da > db) ? da - db : db - da;
    case (step)
      ST_UU: begin ma = {16'd0, u}; mb = {16'd0, u}; end
      ST_UT: begin ma = {16'd0, u}; mb = {15'd0, t, 1'b0}; end
      ST_TT: begin ma = {16'd0, t}; mb = {16'd0, t}; end
      ST_X0: begin ma = w[0]; mb = {1'b0, ofs(cr[bnps_pkg::REG_START_X])}; end
      ST_X1: begin ma = w[1]; mb = {1'b0, ofs(cr[bnps_pkg::REG_CONTROL_X])}; end
      ST_X2: begin ma = w[2]; mb = {1'b0, ofs(cr[bnps_pkg::REG_END_X])}; end
      ST_Y0: begin ma = w[0]; mb = {1'b0, ofs(cr[bnps_pkg::REG_START_Y])}; end
      ST_Y1: begin ma = w[1]; mb = {1'b0, ofs(cr[bnps_pkg::REG_CONTROL_Y])}; end
      ST_Y2: begin ma = w[2]; mb = {1'b0, ofs(cr[bnps_pkg::REG_END_Y])}; end
      ST_DX, ST_DY: begin ma = {1'b0, mag}; mb = {1'b0, mag}; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = {31'd0, ma} * {31'd0, mb};
    dsum = {1'b0, dx2} + {1'b0, prod};
    dsat = dsum[64] ? '1 : dsum[63:0];
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) cr[k] <= '0;
      scount <= 10'd20;
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] < bnps_pkg::REG_NSAMP) cr[paddr[4:2]] <= pwdata;
        else if (paddr[4:2] == bnps_pkg::REG_NSAMP) scount <= pwdata[9:0];
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          qx <= ofs(s_tdata[31:0]);
          qy <= ofs(s_tdata[63:32]);
          tlo <= a_lo;
          span <= a_hi - a_lo;
          n <= n_in;
          idx <= '0;
          first <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (ddone) begin
          t <= tlo + dq;
          step <= ST_UU;
          state <= S_CALC;
        end
        S_CALC: begin
          step <= step + 4'd1;
          case (step)
            ST_UU: w[0] <= prod[32:0];
            ST_UT: w[1] <= prod[32:0];
            ST_TT: begin
              w[2] <= prod[32:0];
              acc <= HALF;
            end
            ST_X0, ST_X1, ST_X2, ST_Y1, ST_Y2: acc <= acc + prod;
            ST_Y0: begin
              px <= acc[63:32];
              acc <= HALF + prod;
            end
            ST_DX: dx2 <= prod;
            ST_DY: dx2 <= dsat;
            ST_CMP: begin
              if (first || dx2 < bd) begin
                bd <= dx2; bt <= t; bx <= ofs(px); by <= ofs(acc[63:32]);
              end
              first <= 1'b0;
              if (idx == n - 10'd1) begin
                state <= S_OUT;
              end else begin
                idx <= idx + 10'd1;
                state <= S_DIV;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          res <= {bd, by, bx, bt};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, res};

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule
